// ===== rtl/tfnar_pkg.sv =====
// ----------------------------------------------------------------------------
// tfnar_pkg: shared types and constants for the tetra face-normal angle block
// Holds the fixed internal widths of the pair datapath, the arctangent
// table for the vectoring rotator and the pair pipeline depth.
// ----------------------------------------------------------------------------
package tfnar_pkg;

   // shrunk face normal components: magnitude below 2^28
   localparam int NRM_W = 29;
   localparam int NORM_MSB = 28;

   // integer square root: one result bit per stage
   localparam int SQ_STEPS = 30;
   // vectoring rotator steps
   localparam int CORDIC_STEPS = 29;

   // pair pipeline: 6 front stages, root, setup, rotator, rounding
   localparam int PAIR_LAT = 6 + SQ_STEPS + 1 + CORDIC_STEPS + 1;

   // angle units: pi = 2^30
   localparam logic [30:0] PI_UNITS = 31'h4000_0000;
   localparam logic [30:0] HALF_PI  = 31'h2000_0000;

   // round(atan(2^-i) * 2^30 / pi)
   localparam logic [28:0] ATAN_TAB [CORDIC_STEPS] = '{
      29'd268435456, 29'd158466703, 29'd83729454, 29'd42502378, 29'd21333666,
      29'd10677233, 29'd5339919, 29'd2670123, 29'd1335082, 29'd667543,
      29'd333772, 29'd166886, 29'd83443, 29'd41722, 29'd20861, 29'd10430,
      29'd5215, 29'd2608, 29'd1304, 29'd652, 29'd326, 29'd163, 29'd81,
      29'd41, 29'd20, 29'd10, 29'd5, 29'd3, 29'd1
   };

   typedef struct packed {
      logic signed [NRM_W-1:0] x;
      logic signed [NRM_W-1:0] y;
      logic signed [NRM_W-1:0] z;
   } nvec_type;

endpackage

// ===== rtl/tfnar_req_if.sv =====
// ----------------------------------------------------------------------------
// tfnar_req_if: vertex channel
// Valid/ready channel carrying the four vertices of one tetrahedron.
// ----------------------------------------------------------------------------
interface tfnar_req_if #(
   parameter int COORD_BITS = 16
);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] v0_x;
   logic signed [COORD_BITS-1:0] v0_y;
   logic signed [COORD_BITS-1:0] v0_z;
   logic signed [COORD_BITS-1:0] v1_x;
   logic signed [COORD_BITS-1:0] v1_y;
   logic signed [COORD_BITS-1:0] v1_z;
   logic signed [COORD_BITS-1:0] v2_x;
   logic signed [COORD_BITS-1:0] v2_y;
   logic signed [COORD_BITS-1:0] v2_z;
   logic signed [COORD_BITS-1:0] v3_x;
   logic signed [COORD_BITS-1:0] v3_y;
   logic signed [COORD_BITS-1:0] v3_z;

   modport source (
      output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
             v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
      input  ready
   );
   modport sink (
      input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
             v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
      output ready
   );
endinterface

// ===== rtl/tfnar_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tfnar_rsp_if: angle result channel
// Valid/ready channel carrying the angle range of one tetrahedron.
// ----------------------------------------------------------------------------
interface tfnar_rsp_if #(
   parameter int ANGLE_BITS = 16
);
   logic valid;
   logic ready;
   logic [ANGLE_BITS-1:0] min_angle;
   logic [ANGLE_BITS-1:0] max_angle;
   logic degenerate;

   modport source (
      output valid, min_angle, max_angle, degenerate,
      input  ready
   );
   modport sink (
      input  valid, min_angle, max_angle, degenerate,
      output ready
   );
endinterface

// ===== rtl/tetra_face_normal_angle_range.sv =====
// ----------------------------------------------------------------------------
// tetra_face_normal_angle_range: min and max angle between face normals
// Usage:
//   req_ch carries four vertices (signed, COORD_BITS each); rsp_ch returns
//   min_angle and max_angle (code 2^(ANGLE_BITS-1) = pi) and degenerate,
//   which is set with both angles zero when any face has zero area.
//   A transfer happens on a rising clock edge with valid and ready high.
//   Pipeline: 73 register stages from request transfer to response valid,
//   the first loaded at the transfer edge. Throughput: one tetrahedron per
//   cycle while the output is not stalled; every stage is registered and
//   the depth is set by the 30-stage square root and the 29-stage rotator
//   in each of the six pair units.
//   Stall: the whole pipeline holds while a response waits and rsp_ch.ready
//   is low; req_ch.ready drops in that cycle, so nothing is lost or repeated.
//   Bubbles stay in place, so the pipeline refills as soon as ready returns.
//   Reset (synchronous, active high) clears all valid bits; data registers
//   are not reset.
// ----------------------------------------------------------------------------
module tetra_face_normal_angle_range import tfnar_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   tfnar_req_if.sink    req_ch,
   tfnar_rsp_if.source  rsp_ch
);

   localparam int DW  = COORD_BITS + 1;
   localparam int NW  = 2 * COORD_BITS + 3;
   localparam int NX  = (NW > NRM_W) ? NW : NRM_W;
   localparam int NSW = $clog2(NW);
   localparam int LAT = 4 + PAIR_LAT + 2;
   localparam int DGL = PAIR_LAT + 3;

   // edge pairs per normal: e10 e20 e30 e21 e31 e02 e32
   localparam int NA [4] = '{1, 0, 3, 5};
   localparam int NB [4] = '{0, 2, 4, 6};
   localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
   localparam int PB [6] = '{1, 2, 3, 2, 3, 3};

   function automatic logic signed [NW-1:0] xmul(
      input logic signed [DW-1:0] p, input logic signed [DW-1:0] q,
      input logic signed [DW-1:0] r, input logic signed [DW-1:0] s);
      return NW'(p) * NW'(q) - NW'(r) * NW'(s);
   endfunction

   function automatic logic [NW-1:0] nmag(input logic signed [NW-1:0] v);
      return v[NW-1] ? NW'(-v) : NW'(v);
   endfunction

   function automatic logic signed [NRM_W-1:0] shrink_c(
      input logic signed [NW-1:0] v, input logic [NSW-1:0] s);
      logic signed [NX-1:0] w;
      w = NX'(v);
      w = w >>> s;
      return w[NRM_W-1:0];
   endfunction

   logic           en;
   logic [LAT-1:0] vld_ff;
   logic [DGL-1:0] dgn_ff;

   // advance whenever the output register is free or being drained
   assign en           = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign rsp_ch.valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_ch.valid};
      end
   end

   // stage 1: edge vectors
   logic signed [COORD_BITS-1:0] pv [4][3];
   logic signed [DW-1:0]         dif_ff [7][3];
   always_comb begin
      pv[0][0] = signed'(req_ch.v0_x[COORD_BITS-1:0]);
      pv[0][1] = signed'(req_ch.v0_y[COORD_BITS-1:0]);
      pv[0][2] = signed'(req_ch.v0_z[COORD_BITS-1:0]);
      pv[1][0] = signed'(req_ch.v1_x[COORD_BITS-1:0]);
      pv[1][1] = signed'(req_ch.v1_y[COORD_BITS-1:0]);
      pv[1][2] = signed'(req_ch.v1_z[COORD_BITS-1:0]);
      pv[2][0] = signed'(req_ch.v2_x[COORD_BITS-1:0]);
      pv[2][1] = signed'(req_ch.v2_y[COORD_BITS-1:0]);
      pv[2][2] = signed'(req_ch.v2_z[COORD_BITS-1:0]);
      pv[3][0] = signed'(req_ch.v3_x[COORD_BITS-1:0]);
      pv[3][1] = signed'(req_ch.v3_y[COORD_BITS-1:0]);
      pv[3][2] = signed'(req_ch.v3_z[COORD_BITS-1:0]);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            dif_ff[0][c] <= DW'(pv[1][c]) - DW'(pv[0][c]);
            dif_ff[1][c] <= DW'(pv[2][c]) - DW'(pv[0][c]);
            dif_ff[2][c] <= DW'(pv[3][c]) - DW'(pv[0][c]);
            dif_ff[3][c] <= DW'(pv[2][c]) - DW'(pv[1][c]);
            dif_ff[4][c] <= DW'(pv[3][c]) - DW'(pv[1][c]);
            dif_ff[5][c] <= DW'(pv[0][c]) - DW'(pv[2][c]);
            dif_ff[6][c] <= DW'(pv[3][c]) - DW'(pv[2][c]);
         end
      end
   end

   // stage 2: face normals
   logic signed [NW-1:0] nrm_ff [4][3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            nrm_ff[k][0] <= xmul(dif_ff[NA[k]][1], dif_ff[NB[k]][2],
                                 dif_ff[NA[k]][2], dif_ff[NB[k]][1]);
            nrm_ff[k][1] <= xmul(dif_ff[NA[k]][2], dif_ff[NB[k]][0],
                                 dif_ff[NA[k]][0], dif_ff[NB[k]][2]);
            nrm_ff[k][2] <= xmul(dif_ff[NA[k]][0], dif_ff[NB[k]][1],
                                 dif_ff[NA[k]][1], dif_ff[NB[k]][0]);
         end
      end
   end

   // stage 3: zero-normal check and shrink amount per normal
   logic signed [NW-1:0] nrm3_ff [4][3];
   logic [NSW-1:0]       sh_ff [4];
   logic [NSW-1:0]       sh_in [4];
   logic                 dgn_in;
   logic [NW-1:0]        nor_v;
   logic [NSW-1:0]       nmsb;
   always_comb begin
      dgn_in = 1'b0;
      for (int k = 0; k < 4; k++) begin
         nor_v = nmag(nrm_ff[k][0]) | nmag(nrm_ff[k][1]) | nmag(nrm_ff[k][2]);
         if (nor_v == '0) dgn_in = 1'b1;
         nmsb = '0;
         for (int bt = 0; bt < NW; bt++) begin
            if (nor_v[bt]) nmsb = NSW'(bt);
         end
         if (int'(nmsb) >= NORM_MSB) begin
            sh_in[k] = NSW'(int'(nmsb) - (NORM_MSB - 1));
         end else begin
            sh_in[k] = '0;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         nrm3_ff <= nrm_ff;
         sh_ff   <= sh_in;
      end
   end

   // degenerate flag rides alongside the pair pipelines
   always_ff @(posedge clock) begin
      if (en) dgn_ff <= {dgn_ff[DGL-2:0], dgn_in};
   end

   // stage 4: shrunk normals
   nvec_type nv_ff [4];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            nv_ff[k].x <= shrink_c(nrm3_ff[k][0], sh_ff[k]);
            nv_ff[k].y <= shrink_c(nrm3_ff[k][1], sh_ff[k]);
            nv_ff[k].z <= shrink_c(nrm3_ff[k][2], sh_ff[k]);
         end
      end
   end

   // six pair units
   logic [ANGLE_BITS-1:0] ang [6];
   for (genvar g = 0; g < 6; g++) begin : g_pair
      tfnar_pair #(
         .ANGLE_BITS (ANGLE_BITS)
      ) u_pair (
         .clock (clock),
         .en    (en),
         .a     (nv_ff[PA[g]]),
         .b     (nv_ff[PB[g]]),
         .angle (ang[g])
      );
   end

   // min/max tree, first level
   logic [ANGLE_BITS-1:0] mn_ff [3];
   logic [ANGLE_BITS-1:0] mx_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            mn_ff[k] <= (ang[2*k] < ang[2*k+1]) ? ang[2*k] : ang[2*k+1];
            mx_ff[k] <= (ang[2*k] > ang[2*k+1]) ? ang[2*k] : ang[2*k+1];
         end
      end
   end

   // second level into the output register
   logic [ANGLE_BITS-1:0] mn01, mx01, lo_in, hi_in;
   logic [ANGLE_BITS-1:0] lo_ff, hi_ff;
   logic                  dgo_ff;
   always_comb begin
      mn01  = (mn_ff[0] < mn_ff[1]) ? mn_ff[0] : mn_ff[1];
      mx01  = (mx_ff[0] > mx_ff[1]) ? mx_ff[0] : mx_ff[1];
      lo_in = (mn01 < mn_ff[2]) ? mn01 : mn_ff[2];
      hi_in = (mx01 > mx_ff[2]) ? mx01 : mx_ff[2];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         dgo_ff <= dgn_ff[DGL-1];
         lo_ff  <= dgn_ff[DGL-1] ? '0 : lo_in;
         hi_ff  <= dgn_ff[DGL-1] ? '0 : hi_in;
      end
   end

   assign rsp_ch.min_angle  = lo_ff;
   assign rsp_ch.max_angle  = hi_ff;
   assign rsp_ch.degenerate = dgo_ff;

endmodule

// ===== rtl/tfnar_pair.sv =====
// ----------------------------------------------------------------------------
// tfnar_pair: angle between two face normals
// Cross and dot product, block scaling, pipelined integer square root and
// a 29-step vectoring rotator; one pair per cycle while en is high.
// ----------------------------------------------------------------------------
module tfnar_pair import tfnar_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  nvec_type              a,
   input  nvec_type              b,
   output logic [ANGLE_BITS-1:0] angle
);

   localparam int PW  = 2 * NRM_W;     // single products
   localparam int TW  = PW + 1;        // cross and dot terms
   localparam int UW  = NORM_MSB + 2;  // scaled terms, magnitude below 2^29
   localparam int SQW = 2 * UW - 1;    // squares
   localparam int RMW = SQW + 2;       // root remainder and trial
   localparam int RTW = SQ_STEPS;      // root
   localparam int CW  = 34;            // rotator words
   localparam int PSW = $clog2(TW);
   localparam int SAW = 5;

   // stage 1: products
   logic signed [PW-1:0] prod_ff [9];
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= PW'(a.y) * PW'(b.z);
         prod_ff[1] <= PW'(a.z) * PW'(b.y);
         prod_ff[2] <= PW'(a.z) * PW'(b.x);
         prod_ff[3] <= PW'(a.x) * PW'(b.z);
         prod_ff[4] <= PW'(a.x) * PW'(b.y);
         prod_ff[5] <= PW'(a.y) * PW'(b.x);
         prod_ff[6] <= PW'(a.x) * PW'(b.x);
         prod_ff[7] <= PW'(a.y) * PW'(b.y);
         prod_ff[8] <= PW'(a.z) * PW'(b.z);
      end
   end

   // stage 2: cross components and dot
   logic signed [TW-1:0] t_ff [4];
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[0] <= TW'(prod_ff[0]) - TW'(prod_ff[1]);
         t_ff[1] <= TW'(prod_ff[2]) - TW'(prod_ff[3]);
         t_ff[2] <= TW'(prod_ff[4]) - TW'(prod_ff[5]);
         t_ff[3] <= TW'(prod_ff[6]) + TW'(prod_ff[7]) + TW'(prod_ff[8]);
      end
   end

   // stage 3: find the shift that puts the largest magnitude at bit 28
   logic signed [TW-1:0] t3_ff [4];
   logic                 sl_ff, sl_in;
   logic [SAW-1:0]       sa_ff, sa_in;
   logic [TW-1:0]        mag_or;
   logic [PSW-1:0]       msb;

   always_comb begin
      mag_or = '0;
      for (int k = 0; k < 4; k++) begin
         mag_or = mag_or | (t_ff[k][TW-1] ? TW'(-t_ff[k]) : TW'(t_ff[k]));
      end
      msb = '0;
      for (int bt = 0; bt < TW; bt++) begin
         if (mag_or[bt]) msb = PSW'(bt);
      end
      sl_in = int'(msb) < NORM_MSB;
      if (sl_in) begin
         sa_in = SAW'(NORM_MSB - int'(msb));
      end else begin
         sa_in = SAW'(int'(msb) - NORM_MSB);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t3_ff <= t_ff;
         sl_ff <= sl_in;
         sa_ff <= sa_in;
      end
   end

   // stage 4: apply the block shift
   logic signed [UW-1:0] u_ff [4];
   logic signed [TW-1:0] shl [4];
   logic signed [TW-1:0] shr [4];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         shl[k] = t3_ff[k] <<< sa_ff;
         shr[k] = t3_ff[k] >>> sa_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            u_ff[k] <= sl_ff ? shl[k][UW-1:0] : shr[k][UW-1:0];
         end
      end
   end

   // stage 5: squares
   logic [SQW-1:0]       sq_ff [3];
   logic signed [UW-1:0] d5_ff;
   logic signed [2*UW-1:0] sq_full [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_full[k] = (2*UW)'(u_ff[k]) * (2*UW)'(u_ff[k]);
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= sq_full[k][SQW-1:0];
         end
         d5_ff <= u_ff[3];
      end
   end

   // stage 6: sum of squares seeds the root pipeline
   logic [RMW-1:0]       rem_ff  [SQ_STEPS+1];
   logic [RTW-1:0]       root_ff [SQ_STEPS+1];
   logic signed [UW-1:0] dq_ff   [SQ_STEPS+1];
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= RMW'(sq_ff[0]) + RMW'(sq_ff[1]) + RMW'(sq_ff[2]);
         root_ff[0] <= '0;
         dq_ff[0]   <= d5_ff;
      end
   end

   // root: decide one bit per stage, most significant first
   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam int BI = SQ_STEPS - 1 - j;
      logic [RMW-1:0] trial;
      assign trial = (RMW'(root_ff[j]) << (BI + 1)) + (RMW'(1) << (2 * BI));
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[j] >= trial) begin
               rem_ff[j+1]  <= rem_ff[j] - trial;
               root_ff[j+1] <= root_ff[j] | (RTW'(1) << BI);
            end else begin
               rem_ff[j+1]  <= rem_ff[j];
               root_ff[j+1] <= root_ff[j];
            end
            dq_ff[j+1] <= dq_ff[j];
         end
      end
   end

   // rotator setup: fold a negative dot into the right half plane
   logic signed [CW-1:0] cx_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] cy_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] cz_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] m_ext, d_ext;
   assign m_ext = signed'(CW'(root_ff[SQ_STEPS]));
   assign d_ext = CW'(dq_ff[SQ_STEPS]);

   always_ff @(posedge clock) begin
      if (en) begin
         if (d_ext < 0) begin
            cx_ff[0] <= m_ext;
            cy_ff[0] <= -d_ext;
            cz_ff[0] <= signed'(CW'(HALF_PI));
         end else begin
            cx_ff[0] <= d_ext;
            cy_ff[0] <= m_ext;
            cz_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [CW-1:0] xs, ys, tv;
      assign xs = cx_ff[i] >>> i;
      assign ys = cy_ff[i] >>> i;
      assign tv = signed'(CW'(ATAN_TAB[i]));
      always_ff @(posedge clock) begin
         if (en) begin
            if (cy_ff[i] > 0) begin
               cx_ff[i+1] <= cx_ff[i] + ys;
               cy_ff[i+1] <= cy_ff[i] - xs;
               cz_ff[i+1] <= cz_ff[i] + tv;
            end else if (cy_ff[i] < 0) begin
               cx_ff[i+1] <= cx_ff[i] - ys;
               cy_ff[i+1] <= cy_ff[i] + xs;
               cz_ff[i+1] <= cz_ff[i] - tv;
            end else begin
               cx_ff[i+1] <= cx_ff[i];
               cy_ff[i+1] <= cy_ff[i];
               cz_ff[i+1] <= cz_ff[i];
            end
         end
      end
   end

   // clamp to [0, pi] and round to the output code
   logic signed [CW-1:0]  zf;
   logic [30:0]           zc, zr;
   logic [ANGLE_BITS-1:0] angle_ff;
   assign zf = cz_ff[CORDIC_STEPS];
   always_comb begin
      if (zf < 0) begin
         zc = '0;
      end else if (zf > signed'(CW'(PI_UNITS))) begin
         zc = PI_UNITS;
      end else begin
         zc = zf[30:0];
      end
      zr = zc + (31'(1) << (30 - ANGLE_BITS));
   end
   always_ff @(posedge clock) begin
      if (en) angle_ff <= zr[30 -: ANGLE_BITS];
   end
   assign angle = angle_ff;

endmodule

// ===== rtl/tfnar_checker.sv =====
// ----------------------------------------------------------------------------
// tfnar_checker: port-level checks for the face-normal angle block
// Watches the request and response channels and the result fields.
// ----------------------------------------------------------------------------
module tfnar_checker #(
   parameter int ANGLE_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [ANGLE_BITS-1:0] min_angle,
   input logic [ANGLE_BITS-1:0] max_angle,
   input logic                  degenerate
);

   localparam logic [ANGLE_BITS-1:0] PI_CODE = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(min_angle)
         && $stable(max_angle) && $stable(degenerate))
      else $error("stalled response changed");

   // a stalled output must stall the input side too
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && degenerate |-> min_angle == '0 && max_angle == '0)
      else $error("degenerate response with nonzero angles");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> min_angle <= max_angle && max_angle <= PI_CODE)
      else $error("angle range out of order or above pi");

endmodule

bind tetra_face_normal_angle_range tfnar_checker #(
   .ANGLE_BITS (ANGLE_BITS)
) u_tfnar_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .min_angle  (rsp_ch.min_angle),
   .max_angle  (rsp_ch.max_angle),
   .degenerate (rsp_ch.degenerate)
);
